// ===== design/u16u8_pkg.sv =====
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types and constants for the UTF-16 to UTF-8 encoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

  localparam int UNIT_W = 16;
  localparam int BYTE_W = 8;
  localparam int CAP_W  = 16;
  localparam int MAX_B  = 4;      // bytes per item, worst case
  localparam int CNT_W  = 3;      // holds 0..MAX_B
  localparam int CODE_W = 21;     // scalar value up to 10FFFF

  localparam logic [UNIT_W-1:0] SURR_MIN  = 16'hD800;
  localparam logic [UNIT_W-1:0] HIGH_MAX  = 16'hDBFF;
  localparam logic [UNIT_W-1:0] LOW_MIN   = 16'hDC00;
  localparam logic [UNIT_W-1:0] SURR_MAX  = 16'hDFFF;
  localparam logic [UNIT_W-1:0] ONE_MAX   = 16'h007F;
  localparam logic [UNIT_W-1:0] TWO_MAX   = 16'h07FF;
  localparam logic [CODE_W-1:0] SUPP_BASE = 21'h010000;
  localparam logic [CAP_W-1:0]  CAP_RESET = 16'd256;
  localparam logic [BYTE_W-1:0] NUL_BYTE  = 8'h00;

  // result of one item, handed from the encoder to the byte serialiser
  typedef struct packed {
    logic [CNT_W-1:0]             count;  // bytes produced, 0 = none
    logic [MAX_B-1:0][BYTE_W-1:0] bytes;  // bytes[0] goes out first
    logic                         term;   // single terminator byte
    logic                         trunc;  // terminator forced by budget
  } enc_res_t;

endpackage

// ===== design/u16u8_if.sv =====
// ----------------------------------------------------------------------------
// u16u8 channel interfaces
// Valid/ready channels for code units, output bytes and the capacity write.
// ----------------------------------------------------------------------------
interface u16u8_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;

  modport source (output valid, output code_unit, input ready);
  modport sink   (input valid, input code_unit, output ready);
endinterface

interface u16u8_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_last;
  logic       string_end;
  logic       truncated;

  modport source (output valid, output out_byte, output run_last,
                  output string_end, output truncated, input ready);
  modport sink   (input valid, input out_byte, input run_last,
                  input string_end, input truncated, output ready);
endinterface

interface u16u8_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_capacity;

  modport source (output valid, output out_capacity, input ready);
  modport sink   (input valid, input out_capacity, output ready);
endinterface

// ===== design/u16u8_encode.sv =====
// ----------------------------------------------------------------------------
// u16u8_encode
// Per-item encode: surrogate pairing, byte budget and string state.
// ----------------------------------------------------------------------------
module u16u8_encode (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic [15:0]             code_unit,
  input  logic                    cfg_we,
  input  logic [15:0]             cfg_data,
  output u16u8_pkg::enc_res_t     res
);
  import u16u8_pkg::*;

  logic [CAP_W-1:0]  cap_r,        cap_nxt;
  logic [CAP_W-1:0]  bytes_left_r, bytes_left_nxt;
  logic [UNIT_W-1:0] held_unit_r,  held_unit_nxt;
  logic              held_valid_r, held_valid_nxt;
  logic              dropping_r,   dropping_nxt;

  logic [CNT_W-1:0]             need;
  logic [MAX_B-1:0][BYTE_W-1:0] chr;
  logic [CODE_W-1:0]            code;
  logic                         pair_ok;

  assign pair_ok = (held_unit_r >= SURR_MIN) && (held_unit_r <= HIGH_MAX) &&
                   (code_unit >= LOW_MIN) && (code_unit <= SURR_MAX);
  assign code    = {1'b0, held_unit_r[9:0], code_unit[9:0]} + SUPP_BASE;

  // character bytes, ignoring budget
  always_comb begin
    chr  = '0;
    need = CNT_W'(1);
    if (held_valid_r) begin
      if (pair_ok) begin
        need   = CNT_W'(4);
        chr[0] = {5'b11110, code[20:18]};
        chr[1] = {2'b10, code[17:12]};
        chr[2] = {2'b10, code[11:6]};
        chr[3] = {2'b10, code[5:0]};
      end else begin
        chr[0] = NUL_BYTE;
      end
    end else if (code_unit <= ONE_MAX) begin
      chr[0] = code_unit[7:0];
    end else if (code_unit <= TWO_MAX) begin
      need   = CNT_W'(2);
      chr[0] = {3'b110, code_unit[10:6]};
      chr[1] = {2'b10, code_unit[5:0]};
    end else begin
      need   = CNT_W'(3);
      chr[0] = {4'b1110, code_unit[15:12]};
      chr[1] = {2'b10, code_unit[11:6]};
      chr[2] = {2'b10, code_unit[5:0]};
    end
  end

  always_comb begin
    res            = '0;
    cap_nxt        = cap_r;
    bytes_left_nxt = bytes_left_r;
    held_unit_nxt  = held_unit_r;
    held_valid_nxt = held_valid_r;
    dropping_nxt   = dropping_r;
    if (cfg_we) begin
      cap_nxt        = cfg_data;
      bytes_left_nxt = cfg_data;
    end else if (accept) begin
      if (dropping_r) begin
        if (code_unit == '0) begin
          dropping_nxt   = 1'b0;
          bytes_left_nxt = cap_r;
        end
      end else if (code_unit == '0) begin
        res.count      = CNT_W'(1);
        res.term       = 1'b1;
        held_valid_nxt = 1'b0;
        held_unit_nxt  = '0;
        bytes_left_nxt = cap_r;
      end else if (!held_valid_r && code_unit >= SURR_MIN && code_unit <= SURR_MAX) begin
        held_unit_nxt  = code_unit;
        held_valid_nxt = 1'b1;
      end else begin
        held_valid_nxt = 1'b0;
        held_unit_nxt  = '0;
        if (bytes_left_r <= CAP_W'(need)) begin
          // no room: forced terminator, drop until end of string
          res.count      = CNT_W'(1);
          res.term       = 1'b1;
          res.trunc      = 1'b1;
          bytes_left_nxt = cap_r;
          dropping_nxt   = 1'b1;
        end else begin
          res.count      = need;
          res.bytes      = chr;
          bytes_left_nxt = bytes_left_r - CAP_W'(need);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r        <= CAP_RESET;
      bytes_left_r <= CAP_RESET;
      held_unit_r  <= '0;
      held_valid_r <= 1'b0;
      dropping_r   <= 1'b0;
    end else begin
      cap_r        <= cap_nxt;
      bytes_left_r <= bytes_left_nxt;
      held_unit_r  <= held_unit_nxt;
      held_valid_r <= held_valid_nxt;
      dropping_r   <= dropping_nxt;
    end
  end

endmodule

// ===== design/u16u8_serial.sv =====
// ----------------------------------------------------------------------------
// u16u8_serial
// Result register: holds up to four bytes and sends one per handshake.
// ----------------------------------------------------------------------------
module u16u8_serial (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  u16u8_pkg::enc_res_t res,
  output logic                can_load,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                run_last,
  output logic                string_end,
  output logic                truncated
);
  import u16u8_pkg::*;

  logic [MAX_B-1:0][BYTE_W-1:0] buf_r, buf_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         term_r, term_nxt;
  logic                         trunc_r, trunc_nxt;
  logic                         pop;

  assign pop      = (cnt_r != '0) && out_ready;
  // free now, or the last byte leaves this cycle
  assign can_load = (cnt_r == '0) || ((cnt_r == CNT_W'(1)) && out_ready);

  assign out_valid  = (cnt_r != '0);
  assign out_byte   = buf_r[0];
  assign run_last   = (cnt_r == CNT_W'(1));
  assign string_end = term_r;
  assign truncated  = trunc_r;

  always_comb begin
    buf_nxt   = buf_r;
    cnt_nxt   = cnt_r;
    term_nxt  = term_r;
    trunc_nxt = trunc_r;
    if (load) begin
      buf_nxt   = res.bytes;
      cnt_nxt   = res.count;
      term_nxt  = res.term;
      trunc_nxt = res.trunc;
    end else if (pop) begin
      buf_nxt   = {NUL_BYTE, buf_r[MAX_B-1:1]};
      cnt_nxt   = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    buf_r <= buf_nxt;
    if (!rst_n) begin
      cnt_r   <= '0;
      term_r  <= 1'b0;
      trunc_r <= 1'b0;
    end else begin
      cnt_r   <= cnt_nxt;
      term_r  <= term_nxt;
      trunc_r <= trunc_nxt;
    end
  end

endmodule

// ===== design/utf16_to_utf8_encoder.sv =====
// Timing: the first byte of an item is offered in the cycle after it is taken.
// Throughput: an item is taken every cycle while each gives at most one byte
//   and the output is not stalled; an item giving more bytes holds the input
//   until its last byte leaves the one-byte-per-cycle result register.
// Reset: synchronous, active low; clears pairing, drop and result state and
//   loads a 256-byte budget. No clearing pass.
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder
// UTF-16 code units in, UTF-8 bytes out, with a per-string byte budget.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder (
  input logic         clk,
  input logic         rst_n,
  u16u8_in_if.sink    in_ch,
  u16u8_out_if.source out_ch,
  u16u8_cfg_if.sink   cfg_ch
);
  import u16u8_pkg::*;

  enc_res_t res;
  logic     can_load;
  logic     accept;

  // Capacity writes always taken; user must keep them to idle (unchecked).
  assign cfg_ch.ready = 1'b1;

  // The encoder updates its state at accept; the result register must be
  // free (or emptying this cycle) before a new item may enter.
  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;

  u16u8_encode u_encode (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .code_unit (in_ch.code_unit),
    .cfg_we    (cfg_ch.valid),
    .cfg_data  (cfg_ch.out_capacity),
    .res       (res)
  );

  // Items that give no byte (held surrogate, dropped units) only touch
  // encoder state and never load the result register.
  u16u8_serial u_serial (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept && (res.count != '0)),
    .res        (res),
    .can_load   (can_load),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_byte   (out_ch.out_byte),
    .run_last   (out_ch.run_last),
    .string_end (out_ch.string_end),
    .truncated  (out_ch.truncated)
  );

endmodule

// ===== design/u16u8_chk.sv =====
// ----------------------------------------------------------------------------
// u16u8_chk
// Port-level checks on the byte output of the encoder.
// ----------------------------------------------------------------------------
module u16u8_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       run_last,
  input logic       string_end,
  input logic       truncated
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(run_last))
    else $error("output byte changed while stalled");

  a_term: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && string_end |-> (out_byte == 8'h00) && run_last)
    else $error("terminator not a lone nul byte");

  a_trunc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && truncated |-> string_end)
    else $error("truncation flag without terminator");

  a_rst: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> !out_valid)
    else $error("output valid straight after reset");

endmodule

bind utf16_to_utf8_encoder u16u8_chk u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .run_last   (out_ch.run_last),
  .string_end (out_ch.string_end),
  .truncated  (out_ch.truncated)
);

// ===== dv/utf16_to_utf8_encoder_tb.sv =====
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder_tb
// Self-checking bench for the UTF-16 to UTF-8 encoder. Code units go in as
// directed cases and then as random strings under a range of byte budgets,
// with random idling and two long output hold-offs. A ledger predicts every
// output byte and checks each accepted byte, field by field, in order.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import u16u8_pkg::*;

  localparam int LIMIT_CYCLES = 300000;
  localparam int HOLD_CYCLES  = 64;     // long output hold-off
  localparam int SETTLE       = 12;     // lets units with no bytes drain
  localparam int UNIT_TARGET  = 340;    // accepted units, directed ones included
  localparam int NUM_PHASES   = 7;

  // UTF-8 lead and continuation markers
  localparam logic [BYTE_W-1:0] LEAD2 = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD3 = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD4 = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT  = 8'h80;

  typedef struct packed {
    logic [BYTE_W-1:0] code_byte;
    logic              run_end;
    logic              term;
    logic              cut;
  } utf8_out_t;

  // --------------------------------------------------------------------------
  // Ledger: mirrors the encoder state and holds the bytes still owed.
  // --------------------------------------------------------------------------
  class transcode_ledger;
    logic [CAP_W-1:0]  capacity;
    logic [CAP_W-1:0]  bytes_left;
    logic [UNIT_W-1:0] held_unit;
    bit                held_valid;
    bit                dropping;
    utf8_out_t         owed_bytes[$];
    int                errors;

    function new();
      capacity   = CAP_RESET;
      bytes_left = CAP_RESET;
      held_unit  = '0;
      held_valid = 1'b0;
      dropping   = 1'b0;
      errors     = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] value);
      capacity   = value;
      bytes_left = value;
    endfunction

    function void owe(logic [BYTE_W-1:0] b, bit run_end, bit term, bit cut);
      utf8_out_t e;
      e.code_byte = b;
      e.run_end   = run_end;
      e.term      = term;
      e.cut       = cut;
      owed_bytes.push_back(e);
    endfunction

    // terminator, either at a zero unit or forced by the budget
    function void end_string(bit forced);
      owe(NUL_BYTE, 1'b1, 1'b1, forced);
      held_valid = 1'b0;
      held_unit  = '0;
      bytes_left = capacity;
      dropping   = forced;
    endfunction

    // returns 1 unless the unit was discarded after a truncation
    function bit take_unit(logic [UNIT_W-1:0] u);
      logic [CODE_W-1:0] code;
      logic [BYTE_W-1:0] enc [MAX_B];
      int                need;
      if (dropping) begin
        if (u == '0) begin
          dropping   = 1'b0;
          bytes_left = capacity;
        end
        return 1'b0;
      end
      if (u == '0) begin
        end_string(1'b0);
        return 1'b1;
      end
      if (held_valid) begin
        held_valid = 1'b0;
        if (held_unit >= SURR_MIN && held_unit <= HIGH_MAX &&
            u >= LOW_MIN && u <= SURR_MAX) begin
          // offsets from D800 and DC00 are just the low ten bits
          code   = {1'b0, held_unit[9:0], u[9:0]} + SUPP_BASE;
          need   = 4;
          enc[0] = LEAD4 | BYTE_W'(code[20:18]);
          enc[1] = CONT  | BYTE_W'(code[17:12]);
          enc[2] = CONT  | BYTE_W'(code[11:6]);
          enc[3] = CONT  | BYTE_W'(code[5:0]);
        end else begin
          need   = 1;
          enc[0] = NUL_BYTE;
        end
        held_unit = '0;
      end else if (u >= SURR_MIN && u <= SURR_MAX) begin
        held_unit  = u;
        held_valid = 1'b1;
        return 1'b1;
      end else if (u <= ONE_MAX) begin
        need   = 1;
        enc[0] = u[7:0];
      end else if (u <= TWO_MAX) begin
        need   = 2;
        enc[0] = LEAD2 | BYTE_W'(u[10:6]);
        enc[1] = CONT  | BYTE_W'(u[5:0]);
      end else begin
        need   = 3;
        enc[0] = LEAD3 | BYTE_W'(u[15:12]);
        enc[1] = CONT  | BYTE_W'(u[11:6]);
        enc[2] = CONT  | BYTE_W'(u[5:0]);
      end
      // one byte is always kept back for the terminator
      if (int'(bytes_left) <= need) begin
        end_string(1'b1);
        return 1'b1;
      end
      bytes_left = bytes_left - CAP_W'(need);
      for (int i = 0; i < need; i++)
        owe(enc[i], i == need - 1, 1'b0, 1'b0);
      return 1'b1;
    endfunction

    function void check_byte(utf8_out_t got);
      utf8_out_t exp_b;
      if (owed_bytes.size() == 0) begin
        $display("%0t: unexpected byte %02h (end %0b term %0b trunc %0b)",
                 $time, got.code_byte, got.run_end, got.term, got.cut);
        errors++;
        return;
      end
      exp_b = owed_bytes.pop_front();
      if (got.code_byte !== exp_b.code_byte) begin
        $display("%0t: out_byte expected %02h got %02h",
                 $time, exp_b.code_byte, got.code_byte);
        errors++;
      end
      if (got.run_end !== exp_b.run_end) begin
        $display("%0t: run_last expected %0b got %0b",
                 $time, exp_b.run_end, got.run_end);
        errors++;
      end
      if (got.term !== exp_b.term) begin
        $display("%0t: string_end expected %0b got %0b",
                 $time, exp_b.term, got.term);
        errors++;
      end
      if (got.cut !== exp_b.cut) begin
        $display("%0t: truncated expected %0b got %0b",
                 $time, exp_b.cut, got.cut);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  u16u8_in_if  in_bus();
  u16u8_out_if out_bus();
  u16u8_cfg_if cfg_bus();

  utf16_to_utf8_encoder dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  transcode_ledger ledger = new();

  int  sent_units = 0;   // every accepted unit, dropped ones included
  int  cycles     = 0;
  bit  calm       = 1'b0; // set for a stretch with no idling on either side
  int  holds_asked = 0;   // bumped by the stimulus to request a long hold-off
  int  holds_done  = 0;

  // every input known from time zero
  initial begin
    in_bus.valid         = 1'b0;
    in_bus.code_unit     = '0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.out_capacity = '0;
    out_bus.ready        = 1'b0;
  end

  function automatic bit take_break();
    return !calm && ($urandom_range(99) < 18);
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: predict on accepted units and config writes, then check bytes.
  // Everything is sampled at the edge, before the block updates.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    utf8_out_t got;
    if (rst_n) begin
      if (cfg_bus.valid && cfg_bus.ready)
        ledger.set_capacity(cfg_bus.out_capacity);
      if (in_bus.valid && in_bus.ready) begin
        sent_units++;
        void'(ledger.take_unit(in_bus.code_unit));
      end
      if (out_bus.valid && out_bus.ready) begin
        got.code_byte = out_bus.out_byte;
        got.run_end   = out_bus.run_last;
        got.term      = out_bus.string_end;
        got.cut       = out_bus.truncated;
        ledger.check_byte(got);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, plus a long hold-off on request so the
  // encoder fills up and stops taking units.
  // --------------------------------------------------------------------------
  initial begin
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_bus.ready <= !take_break();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offers one unit and returns at the edge that takes it; valid stays high
  // so back-to-back units keep it up without a glitch.
  task automatic send_unit(input logic [UNIT_W-1:0] u);
    while (take_break()) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.code_unit <= u;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
  endtask

  // Drops valid and waits for every owed byte, then lets the encoder settle in
  // case the last units were held surrogates or dropped ones.
  task automatic drain();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (ledger.owed_bytes.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] value);
    drain();
    cfg_bus.valid        <= 1'b1;
    cfg_bus.out_capacity <= value;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  // One character's worth of units, mostly well formed. Sets ended when the
  // units themselves closed the string (a high surrogate then zero).
  task automatic send_random_char(output bit ended);
    logic [UNIT_W-1:0] hi;
    logic [UNIT_W-1:0] lo;
    int                pick;
    ended = 1'b0;
    pick  = $urandom_range(99);
    hi    = UNIT_W'($urandom_range(HIGH_MAX, SURR_MIN));
    lo    = UNIT_W'($urandom_range(SURR_MAX, LOW_MIN));
    if (pick < 30) begin
      send_unit(UNIT_W'($urandom_range(ONE_MAX, 1)));
    end else if (pick < 48) begin
      send_unit(UNIT_W'($urandom_range(TWO_MAX, ONE_MAX + 1)));
    end else if (pick < 66) begin
      if ($urandom_range(1))
        send_unit(UNIT_W'($urandom_range(SURR_MIN - 1, TWO_MAX + 1)));
      else
        send_unit(UNIT_W'($urandom_range(16'hFFFF, SURR_MAX + 1)));
    end else if (pick < 84) begin
      send_unit(hi);
      send_unit(lo);
    end else if (pick < 89) begin
      // high surrogate followed by anything but a low one
      send_unit(hi);
      if ($urandom_range(1))
        send_unit(UNIT_W'($urandom_range(HIGH_MAX, 1)));
      else
        send_unit(UNIT_W'($urandom_range(16'hFFFF, SURR_MAX + 1)));
    end else if (pick < 93) begin
      // lone low surrogate, second unit eaten whatever it is
      send_unit(lo);
      send_unit(UNIT_W'($urandom_range(16'hFFFF, 1)));
    end else if (pick < 96) begin
      send_unit(hi);
      send_unit('0);
      ended = 1'b1;
    end else begin
      send_unit(UNIT_W'($urandom_range(16'hFFFF, 1)));
    end
  endtask

  task automatic send_random_string();
    int n;
    bit ended;
    n = $urandom_range(20, 1);
    for (int i = 0; i < n; i++) begin
      send_random_char(ended);
      if (ended) return;
    end
    send_unit('0);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    logic [CAP_W-1:0] caps [NUM_PHASES];
    int               phase_goal;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset budget of 256: every width class and its edges
    send_unit(16'h0041);
    send_unit(ONE_MAX);
    send_unit(UNIT_W'(ONE_MAX + 1));
    send_unit(TWO_MAX);
    send_unit(UNIT_W'(TWO_MAX + 1));
    send_unit(UNIT_W'(SURR_MIN - 1));
    send_unit(UNIT_W'(SURR_MAX + 1));
    send_unit(16'hFFFF);
    send_unit(SURR_MIN); send_unit(LOW_MIN);      // lowest supplementary
    send_unit(HIGH_MAX); send_unit(SURR_MAX);     // 10FFFF
    send_unit(SURR_MIN); send_unit(16'h0041);     // high then plain: error
    send_unit(LOW_MIN);  send_unit(SURR_MIN);     // low first: error
    send_unit(HIGH_MAX); send_unit(HIGH_MAX);     // two highs: error
    send_unit(SURR_MIN); send_unit('0);           // zero as second unit
    send_unit('0);                                // empty string
    send_unit(16'h0001);
    send_unit('0);

    // smallest budget: only the terminator fits, anything else truncates
    write_capacity(16'd1);
    send_unit(16'h0041);
    send_unit(16'h0042);                          // dropped
    send_unit(SURR_MIN);                          // dropped
    send_unit('0);                                // ends the drop, silent
    send_unit('0);

    // four bytes fit exactly once, the next byte does not
    write_capacity(16'd5);
    send_unit(16'hD83D); send_unit(16'hDE00);
    send_unit(16'h0041);
    send_unit('0);

    // random strings over a spread of budgets, extremes included
    caps[0] = 16'hFFFF;
    caps[1] = 16'd3;
    caps[2] = 16'd12;
    caps[3] = CAP_W'($urandom_range(64, 1));
    caps[4] = 16'd40;
    caps[5] = CAP_RESET;
    caps[6] = CAP_W'($urandom_range(16'hFFFF, 1));
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(caps[p]);
      calm = (p == 2);
      if (p == 0 || p == 4)
        holds_asked++;
      phase_goal = (UNIT_TARGET * (p + 1)) / NUM_PHASES;
      while (sent_units < phase_goal)
        send_random_string();
    end
    calm = 1'b0;

    drain();
    if (ledger.errors == 0 && ledger.owed_bytes.size() == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
